@@ sv/osp_pkg.sv @@
// Shared types, constants and the arctangent table for the ocean spectrum evolution pipeline.
`default_nettype none
package osp_pkg;

  // configuration register indexes
  localparam logic REG_KX_STEP = 1'b0;
  localparam logic REG_KY_STEP = 1'b1;

  localparam logic [31:0] KSTEP_RESET = 32'd1054099;
  localparam logic [19:0] G_Q16       = 20'd642908;
  localparam logic [17:0] LSQ_Q24     = 18'd167772;
  localparam logic [63:0] TWOPI_Q32   = 64'd26986075409;
  localparam logic signed [36:0] PI_Q32     = 37'sd13493037705;
  localparam logic signed [36:0] TWOPI_S    = 37'sd26986075409;
  localparam logic signed [36:0] HALFPI_Q32 = 37'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30_M1 = 34'sd1073741823;

  localparam int SQ1_STEPS    = 28;
  localparam int SQ2_STEPS    = 32;
  localparam int MOD_STEPS    = 30;
  localparam int CORDIC_STEPS = 24;
  localparam int SQ1_W        = 57;
  localparam int SQ2_W        = 65;

  // sideband that travels with every item down the pipe
  typedef struct packed {
    logic        valid;
    logic        req;
    logic        sat;
    logic        neg;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [63:0] data;
    logic [34:0] aux;
  } side_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      default: v = (i < 30) ? (30'd1 << (30 - i)) : 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/osp_sqrt_cell.sv @@
// One digit step of a pipelined integer square root.
`default_nettype none
module osp_sqrt_cell import osp_pkg::*; #(
  parameter int W  = 64,
  parameter int SH = 0
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire side_t        side_i,
  input  wire logic [W-1:0] v_i,
  input  wire logic [W-1:0] r_i,
  output side_t             side_o,
  output logic [W-1:0]      v_o,
  output logic [W-1:0]      r_o
);

  localparam logic [W-1:0] BIT_C = W'(1) << SH;

  side_t        side_r;
  logic [W-1:0] v_r, r_r, v_nxt, r_nxt, trial;

  always_comb begin
    trial = r_i + BIT_C;
    if (v_i >= trial) begin
      v_nxt = v_i - trial;
      r_nxt = (r_i >> 1) + BIT_C;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign side_o = side_r;
  assign v_o    = v_r;
  assign r_o    = r_r;

endmodule
`default_nettype wire

@@ sv/osp_mod_cell.sv @@
// One compare-and-subtract step of the phase reduction modulo 2*pi.
`default_nettype none
module osp_mod_cell import osp_pkg::*; #(
  parameter int SH = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire side_t       side_i,
  input  wire logic [63:0] v_i,
  output side_t            side_o,
  output logic [63:0]      v_o
);

  localparam logic [63:0] M = TWOPI_Q32 << SH;

  side_t       side_r;
  logic [63:0] v_r, v_nxt;

  assign v_nxt = (v_i >= M) ? v_i - M : v_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end

  assign side_o = side_r;
  assign v_o    = v_r;

endmodule
`default_nettype wire

@@ sv/osp_cordic_cell.sv @@
// One rotation step of the cos/sin CORDIC.
`default_nettype none
module osp_cordic_cell import osp_pkg::*; #(
  parameter int I = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire side_t              side_i,
  input  wire logic signed [33:0] x_i,
  input  wire logic signed [33:0] y_i,
  input  wire logic signed [33:0] z_i,
  output side_t                   side_o,
  output logic signed [33:0]      x_o,
  output logic signed [33:0]      y_o,
  output logic signed [33:0]      z_o
);

  localparam logic signed [33:0] ATAN = signed'(34'(atan_q30(I)));

  side_t              side_r;
  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;

  always_comb begin
    if (z_i >= 0) begin
      x_nxt = x_i - (y_i >>> I);
      y_nxt = y_i + (x_i >>> I);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> I);
      y_nxt = y_i - (x_i >>> I);
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule
`default_nettype wire

@@ sv/ocean_spectrum_time_evolve.sv @@
// Top level: ocean spectrum time evolution pipeline with the h0 spectrum memory.
//
//  port group | dir | contents
//  in_*       | in  | load or compute item (tuser = req_type)
//  out_*      | out | evolved spectrum value, one per in-range compute item
//  cfg_*      | in  | kx_step / ky_step writes
//
// One item per cycle while the output is not stalled; the pipe holds two square-root
// cell rows, a modulo row and a CORDIC row. Every stage moves when the output register
// is empty or being taken, so a stalled output holds the whole row of cells.
// Loads and computes share the pipe and touch the memory at the same late stage,
// keeping memory order equal to item order. Reset clears valid bits and the step registers.
`default_nettype none
module ocean_spectrum_time_evolve import osp_pkg::*; #(
  parameter int NX = 64,
  parameter int NY = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // col_index[6:0], row_index[13:7], load_re[45:14], load_im[77:46], time_val[109:78]
  input  wire logic [111:0] in_tdata,
  // req_type[0]
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_re[31:0], out_im[63:32]
  output logic [63:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int DEPTH = (NX + 1) * (NY + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic        en;
  logic [31:0] kx_step_r, ky_step_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_step_r <= KSTEP_RESET;
      ky_step_r <= KSTEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KX_STEP: kx_step_r <= cfg_wdata;
        REG_KY_STEP: ky_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- input stage
  side_t       s1_nxt, s1_r, s2_r, s3_r, s4_r;
  logic [6:0]  in_x, in_y;
  logic        in_ok;

  assign in_x  = in_tdata[6:0];
  assign in_y  = in_tdata[13:7];
  assign in_ok = (32'(in_x) <= 32'(NX)) && (32'(in_y) <= 32'(NY));

  always_comb begin
    s1_nxt       = '0;
    s1_nxt.valid = in_tvalid && in_ok;
    s1_nxt.req   = in_tuser[0];
    s1_nxt.x     = in_x;
    s1_nxt.y     = in_y;
    s1_nxt.data  = in_tuser[0] ? {32'd0, in_tdata[109:78]} : in_tdata[77:14];
  end

  logic [38:0] px_r, py_r;
  logic [61:0] sqx_r, sqy_r;
  logic [62:0] k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= 39'(s1_r.x) * 39'(kx_step_r);
      py_r  <= 39'(s1_r.y) * 39'(ky_step_r);
      sqx_r <= 62'(px_r[38:8]) * 62'(px_r[38:8]);
      sqy_r <= 62'(py_r[38:8]) * 62'(py_r[38:8]);
      k2_r  <= 63'(sqx_r) + 63'(sqy_r);
    end
  end

  // ---------------- wave number: sqrt(k2), dispersion term rides along
  side_t       sq1_side [0:SQ1_STEPS];
  logic [SQ1_W-1:0] sq1_v [0:SQ1_STEPS];
  logic [SQ1_W-1:0] sq1_r [0:SQ1_STEPS];
  logic [57:0] disp_m;

  assign disp_m = 58'(k2_r[55:16]) * 58'(LSQ_Q24);

  always_comb begin
    sq1_side[0]     = s4_r;
    sq1_side[0].sat = |k2_r[62:56];
    sq1_side[0].aux = 35'd65536 + 35'(disp_m[57:24]);
  end
  assign sq1_v[0] = SQ1_W'(k2_r[55:0]);
  assign sq1_r[0] = '0;

  for (genvar j = 0; j < SQ1_STEPS; j++) begin : g_sq1
    osp_sqrt_cell #(.W(SQ1_W), .SH(54 - 2 * j)) u_cell (
      .clk, .rst_n, .en,
      .side_i(sq1_side[j]), .v_i(sq1_v[j]), .r_i(sq1_r[j]),
      .side_o(sq1_side[j+1]), .v_o(sq1_v[j+1]), .r_o(sq1_r[j+1])
    );
  end

  side_t       sf_r;
  logic [31:0] gk_r;
  logic [47:0] gk_m;

  assign gk_m = 48'(G_Q16) * 48'(sq1_r[SQ1_STEPS][27:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r.valid <= 1'b0;
    end else if (en) begin
      sf_r <= sq1_side[SQ1_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gk_r <= gk_m[47:16];
    end
  end

  // ---------------- angular frequency: sqrt(gk * disp)
  side_t       sq2_side [0:SQ2_STEPS];
  logic [SQ2_W-1:0] sq2_v [0:SQ2_STEPS];
  logic [SQ2_W-1:0] sq2_r [0:SQ2_STEPS];
  logic [66:0] wsq;

  assign wsq = 67'(gk_r) * 67'(sf_r.aux);

  always_comb begin
    sq2_side[0]     = sf_r;
    sq2_side[0].sat = sf_r.sat || (|wsq[66:64]);
  end
  assign sq2_v[0] = SQ2_W'(wsq[63:0]);
  assign sq2_r[0] = '0;

  for (genvar j = 0; j < SQ2_STEPS; j++) begin : g_sq2
    osp_sqrt_cell #(.W(SQ2_W), .SH(62 - 2 * j)) u_cell (
      .clk, .rst_n, .en,
      .side_i(sq2_side[j]), .v_i(sq2_v[j]), .r_i(sq2_r[j]),
      .side_o(sq2_side[j+1]), .v_o(sq2_v[j+1]), .r_o(sq2_r[j+1])
    );
  end

  side_t       sh_r;
  logic [31:0] w_q16;
  logic [63:0] ph_r;

  assign w_q16 = sq2_side[SQ2_STEPS].sat ? 32'hFFFF_FFFF : sq2_r[SQ2_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r.valid <= 1'b0;
    end else if (en) begin
      sh_r <= sq2_side[SQ2_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= 64'(sq2_side[SQ2_STEPS].data[31:0]) * 64'(w_q16);
    end
  end

  // ---------------- phase modulo 2*pi
  side_t       md_side [0:MOD_STEPS];
  logic [63:0] md_v    [0:MOD_STEPS];

  assign md_side[0] = sh_r;
  assign md_v[0]    = ph_r;

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    osp_mod_cell #(.SH(MOD_STEPS - 1 - j)) u_cell (
      .clk, .rst_n, .en,
      .side_i(md_side[j]), .v_i(md_v[j]),
      .side_o(md_side[j+1]), .v_o(md_v[j+1])
    );
  end

  // fold to [-pi/2, pi/2]; a fold by pi flips the sign of cos and sin
  side_t              fold_nxt, fold_r;
  logic signed [36:0] th0, th1;
  logic signed [33:0] z_r;

  always_comb begin
    fold_nxt = md_side[MOD_STEPS];
    th0      = signed'({1'b0, md_v[MOD_STEPS][35:0]});
    if (th0 > PI_Q32) begin
      th0 = th0 - TWOPI_S;
    end
    th1          = th0;
    fold_nxt.neg = 1'b0;
    if (th0 > HALFPI_Q32) begin
      th1          = th0 - PI_Q32;
      fold_nxt.neg = 1'b1;
    end else if (th0 < -HALFPI_Q32) begin
      th1          = th0 + PI_Q32;
      fold_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r.valid <= 1'b0;
    end else if (en) begin
      fold_r <= fold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r <= 34'(th1 >>> 2);
    end
  end

  // ---------------- CORDIC row
  side_t              cd_side [0:CORDIC_STEPS];
  logic signed [33:0] cd_x    [0:CORDIC_STEPS];
  logic signed [33:0] cd_y    [0:CORDIC_STEPS];
  logic signed [33:0] cd_z    [0:CORDIC_STEPS];

  assign cd_side[0] = fold_r;
  assign cd_x[0]    = GAIN_Q30;
  assign cd_y[0]    = '0;
  assign cd_z[0]    = z_r;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    osp_cordic_cell #(.I(j)) u_cell (
      .clk, .rst_n, .en,
      .side_i(cd_side[j]), .x_i(cd_x[j]), .y_i(cd_y[j]), .z_i(cd_z[j]),
      .side_o(cd_side[j+1]), .x_o(cd_x[j+1]), .y_o(cd_y[j+1]), .z_o(cd_z[j+1])
    );
  end

  // ---------------- clamp, addresses
  side_t              sj_nxt, sj_r;
  logic signed [33:0] cx, cy, cc, cs;
  logic [AW-1:0]      haddr_r, maddr_r;
  logic [31:0]        here_w, mirr_w;

  function automatic logic signed [33:0] clamp_unit(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = v;
    if (v > ONE_Q30_M1) begin
      r = ONE_Q30_M1;
    end else if (v < -ONE_Q30_M1) begin
      r = -ONE_Q30_M1;
    end
    return r;
  endfunction

  always_comb begin
    sj_nxt = cd_side[CORDIC_STEPS];
    cx     = sj_nxt.neg ? -cd_x[CORDIC_STEPS] : cd_x[CORDIC_STEPS];
    cy     = sj_nxt.neg ? -cd_y[CORDIC_STEPS] : cd_y[CORDIC_STEPS];
    cc     = clamp_unit(cx);
    cs     = clamp_unit(cy);
    if (sj_nxt.req) begin
      sj_nxt.data = {cs[31:0], cc[31:0]};
    end
    here_w = 32'(sj_nxt.x) * 32'(NY + 1) + 32'(sj_nxt.y);
    mirr_w = (32'(NX) - 32'(sj_nxt.x)) * 32'(NY + 1) + (32'(NY) - 32'(sj_nxt.y));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sj_r.valid <= 1'b0;
    end else if (en) begin
      sj_r <= sj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      haddr_r <= here_w[AW-1:0];
      maddr_r <= mirr_w[AW-1:0];
    end
  end

  // ---------------- spectrum memory {im, re}
  logic [63:0] spec_mem [0:DEPTH-1];
  logic [63:0] rd_h_r, rd_m_r;
  side_t       sk_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sj_r.valid && !sj_r.req) begin
        spec_mem[haddr_r] <= sj_r.data;
      end
      rd_h_r <= spec_mem[haddr_r];
      rd_m_r <= spec_mem[maddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_r.valid <= 1'b0;
    end else if (en) begin
      sk_r <= sj_r;
    end
  end

  // ---------------- complex products
  logic signed [32:0] sum_re, sum_im, dif_re, dif_im;
  logic signed [31:0] c_v, s_v;
  logic signed [64:0] p_rc_r, p_is_r, p_ic_r, p_rs_r;
  side_t              sl_r;

  always_comb begin
    sum_re = 33'(signed'(rd_h_r[31:0])) + 33'(signed'(rd_m_r[31:0]));
    sum_im = 33'(signed'(rd_h_r[63:32])) + 33'(signed'(rd_m_r[63:32]));
    dif_re = 33'(signed'(rd_h_r[31:0])) - 33'(signed'(rd_m_r[31:0]));
    dif_im = 33'(signed'(rd_h_r[63:32])) - 33'(signed'(rd_m_r[63:32]));
    c_v    = signed'(sk_r.data[31:0]);
    s_v    = signed'(sk_r.data[63:32]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r.valid <= 1'b0;
    end else if (en) begin
      sl_r <= sk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rc_r <= 65'(sum_re) * 65'(c_v);
      p_is_r <= 65'(sum_im) * 65'(s_v);
      p_ic_r <= 65'(dif_im) * 65'(c_v);
      p_rs_r <= 65'(dif_re) * 65'(s_v);
    end
  end

  // ---------------- round, saturate, output register
  function automatic logic [31:0] sat_out(input logic signed [65:0] acc);
    logic signed [65:0] t;
    logic signed [35:0] v;
    logic [31:0]        r;
    t = acc + 66'sd536870912;
    v = 36'(t >>> 30);
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [65:0] acc_re, acc_im;
  logic               out_v_r;
  logic [63:0]        out_d_r;

  assign acc_re = 66'(p_rc_r) - 66'(p_is_r);
  assign acc_im = 66'(p_ic_r) + 66'(p_rs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= sl_r.valid && sl_r.req;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= {sat_out(acc_im), sat_out(acc_re)};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
`default_nettype wire

@@ tb/osp_checker.sv @@
// Checker for the ocean spectrum evolution block: predicts each result and compares it.
`timescale 1ns / 1ps
module osp_checker import osp_pkg::*; #(
  parameter int NX = 64,
  parameter int NY = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [111:0] in_tdata,
  input  wire logic [0:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [63:0]  out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  output int                errors,
  output int                pending,
  output int                checked
);

  typedef struct packed {
    logic [31:0] im;
    logic [31:0] re;
  } cval_t;

  localparam longint ATAN_TAB [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  logic [31:0]        kx_q;
  logic [31:0]        ky_q;
  logic signed [31:0] h0_re [0:(NX+1)*(NY+1)-1];
  logic signed [31:0] h0_im [0:(NX+1)*(NY+1)-1];
  cval_t              evolved_q [$];
  int                 err_cnt = 0;

  assign errors = err_cnt;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // angular frequency in Q16.16, saturating on huge wave numbers
  function automatic logic [31:0] omega(input int x, input int y);
    logic [63:0]  kx, ky, k2, k, disp, gk;
    logic [127:0] prod;
    kx = (64'(x) * 64'(kx_q)) >> 8;
    ky = (64'(y) * 64'(ky_q)) >> 8;
    k2 = kx * kx + ky * ky;
    if (k2 >= (64'h1 << 56)) return 32'hFFFF_FFFF;
    k = sqrt_floor(k2);
    disp = 64'd65536 + (((k2 >> 16) * 64'(LSQ_Q24)) >> 24);
    gk = (64'(G_Q16) * k) >> 16;
    prod = 128'(gk) * 128'(disp);
    if (prod[127:64] != 0) return 32'hFFFF_FFFF;
    return 32'(sqrt_floor(prod[63:0]));
  endfunction

  function automatic void unit_rot(input logic [63:0] ph, output longint c, output longint s);
    longint th, cx, cy, z, nx, ny;
    bit     neg;
    th = longint'(ph % TWOPI_Q32);
    cx = GAIN_Q30;
    cy = 0;
    neg = 0;
    if (th > longint'(PI_Q32)) th -= longint'(TWOPI_S);
    if (th > longint'(HALFPI_Q32)) begin
      th -= longint'(PI_Q32);
      neg = 1;
    end else if (th < -longint'(HALFPI_Q32)) begin
      th += longint'(PI_Q32);
      neg = 1;
    end
    z = th >>> 2;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z += ATAN_TAB[i];
      end
      cx = nx;
      cy = ny;
    end
    if (neg) begin
      cx = -cx;
      cy = -cy;
    end
    c = (cx > longint'(ONE_Q30_M1)) ? longint'(ONE_Q30_M1) :
        (cx < -longint'(ONE_Q30_M1)) ? -longint'(ONE_Q30_M1) : cx;
    s = (cy > longint'(ONE_Q30_M1)) ? longint'(ONE_Q30_M1) :
        (cy < -longint'(ONE_Q30_M1)) ? -longint'(ONE_Q30_M1) : cy;
  endfunction

  function automatic logic [31:0] round_sat(input logic signed [95:0] acc);
    logic signed [95:0] v;
    v = (acc + 96'sd536870912) >>> 30;
    if (v > 96'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -96'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic cval_t evolve_point(input int x, input int y, input logic [31:0] t);
    longint             c, s;
    int                 here, mirr;
    logic signed [95:0] sr, si, dr, di, cc, ss;
    cval_t              res;
    here = x * (NY + 1) + y;
    mirr = (NX - x) * (NY + 1) + (NY - y);
    unit_rot(64'(t) * 64'(omega(x, y)), c, s);
    sr = 96'(h0_re[here]) + 96'(h0_re[mirr]);
    si = 96'(h0_im[here]) + 96'(h0_im[mirr]);
    dr = 96'(h0_re[here]) - 96'(h0_re[mirr]);
    di = 96'(h0_im[here]) - 96'(h0_im[mirr]);
    cc = 96'(c);
    ss = 96'(s);
    res.re = round_sat(sr * cc - si * ss);
    res.im = round_sat(di * cc + dr * ss);
    return res;
  endfunction

  always @(posedge clk) begin
    int    x, y;
    cval_t exp_v, got;
    if (!rst_n) begin
      evolved_q.delete();
      kx_q <= KSTEP_RESET;
      ky_q <= KSTEP_RESET;
      pending <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_KX_STEP: kx_q <= cfg_wdata;
          REG_KY_STEP: ky_q <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        x = int'(in_tdata[6:0]);
        y = int'(in_tdata[13:7]);
        if (x <= NX && y <= NY) begin
          if (in_tuser[0] == 1'b0) begin
            h0_re[x * (NY + 1) + y] = in_tdata[45:14];
            h0_im[x * (NY + 1) + y] = in_tdata[77:46];
          end else begin
            evolved_q.push_back(evolve_point(x, y, in_tdata[109:78]));
          end
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (evolved_q.size() == 0) begin
          report($sformatf("result %h with nothing expected", out_tdata));
        end else begin
          exp_v = evolved_q.pop_front();
          if (got.re !== exp_v.re)
            report($sformatf("out_re got %h want %h", got.re, exp_v.re));
          if (got.im !== exp_v.im)
            report($sformatf("out_im got %h want %h", got.im, exp_v.im));
          checked <= checked + 1;
        end
      end
      pending <= evolved_q.size();
    end
  end

endmodule

@@ tb/ocean_spectrum_time_evolve_tb.sv @@
// Testbench top for the ocean spectrum evolution block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module ocean_spectrum_time_evolve_tb;
  import osp_pkg::*;

  localparam int NX = 64;
  localparam int NY = 64;
  localparam int DRAIN_CYCLES = 150;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [63:0]  out_tdata;
  logic         cfg_we = 0;
  logic [0:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  int           errors, pending, checked;

  bit  written [0:NX][0:NY];
  bit  no_idle;
  bit  hold_req;
  int  n_loads, n_noise;

  ocean_spectrum_time_evolve #(.NX(NX), .NY(NY)) dut (.*);

  osp_checker #(.NX(NX), .NY(NY)) chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #5_000_000;
    $display("ocean_spectrum_time_evolve_tb: errors");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit rdy;
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      g = draw_gap();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1;
      do begin
        @(negedge clk);
        rdy = out_tvalid;
        @(posedge clk);
      end while (!rdy);
    end
  end

  task automatic send_item(input bit req, input int x, input int y,
                           input logic [31:0] re, input logic [31:0] im,
                           input logic [31:0] t);
    int g;
    bit rdy;
    g = draw_gap();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, t, im, re, 7'(y), 7'(x)};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    if (req == 1'b0 && x <= NX && y <= NY) written[x][y] = 1;
    if (req == 1'b0) n_loads++;
  endtask

  function automatic logic [31:0] pick_h0();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_point(input int x, input int y);
    send_item(1'b0, x, y, pick_h0(), pick_h0(), 32'h0);
  endtask

  // compute only where both the point and its mirror hold a loaded entry
  task automatic compute_point(input int x, input int y, input logic [31:0] t);
    if (!written[x][y]) load_point(x, y);
    if (!written[NX - x][NY - y]) load_point(NX - x, NY - y);
    send_item(1'b1, x, y, $urandom, $urandom, t);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 0;
  endtask

  task automatic noise_item();
    int x, y;
    x = $urandom_range(0, 127);
    y = (x > NX) ? $urandom_range(0, 127) : $urandom_range(NY + 1, 127);
    send_item(1'(($urandom)), x, y, $urandom, $urandom, $urandom);
    n_noise++;
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: noise_item();
        1, 2: load_point($urandom_range(0, NX), $urandom_range(0, NY));
        default: compute_point($urandom_range(0, NX), $urandom_range(0, NY), pick_time());
      endcase
    end
  endtask

  initial begin
    logic [31:0] kx_set [0:4];
    logic [31:0] ky_set [0:4];
    kx_set = '{32'h0, 32'hFFFF_FFFF, 32'd8432792, 32'd1, $urandom};
    ky_set = '{32'h0, 32'hFFFF_FFFF, 32'd123, 32'hFFFF_FFFF, $urandom};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, mirror pairs, overwrite, out-of-range items
    send_item(1'b0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_item(1'b0, NX, NY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_item(1'b1, 0, 0, 32'h0, 32'h0, 32'h0);
    send_item(1'b1, NX, NY, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(1'b0, 32, 32, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    send_item(1'b1, 32, 32, 32'h0, 32'h0, 32'h0003_8000);
    send_item(1'b0, 32, 32, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_item(1'b1, 32, 32, 32'h0, 32'h0, 32'h1234_5678);
    send_item(1'b0, NX, 0, 32'h8000_0000, 32'h8000_0000, 32'h0);
    send_item(1'b0, 0, NY, 32'h8000_0000, 32'h8000_0000, 32'h0);
    send_item(1'b1, NX, 0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(1'b1, 0, NY, 32'h0, 32'h0, 32'h8000_0000);
    send_item(1'b0, 127, 5, 32'h1, 32'h1, 32'h0);
    send_item(1'b0, 3, 127, 32'h1, 32'h1, 32'h0);
    send_item(1'b1, NX + 1, 0, 32'h0, 32'h0, 32'h1);
    send_item(1'b1, 0, NY + 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    compute_point(1, 63, 32'h0000_0001);
    compute_point(63, 1, 32'h7FFF_FFFF);
    random_phase(40);

    // long output hold-off while items keep coming, so the pipe backs up
    drain();
    hold_req = 1;
    no_idle = 1;
    for (int i = 0; i < 100; i++)
      compute_point($urandom_range(0, NX), $urandom_range(0, NY), pick_time());
    no_idle = 0;
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_KX_STEP, kx_set[p]);
      write_reg(REG_KY_STEP, ky_set[p]);
      random_phase(40);
      drain();
    end

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d checked results, %0d loads, %0d out-of-range items", checked,
             n_loads, n_noise);
    $display("six wave-number step settings incl. zero and all-ones, one long output stall");
    if (errors == 0 && pending == 0) begin
      $display("ocean_spectrum_time_evolve_tb: clean");
    end else begin
      $display("ocean_spectrum_time_evolve_tb: errors");
    end
    $finish;
  end

endmodule
